// ----- rtl/ngm_pkg.sv -----
// shared types, constants and helper functions of the order-3 markov generator
// depends on nothing
`default_nettype none
package ngm_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned NSYM           = 27;
  localparam int unsigned TABLE_DEPTH    = 531441;
  localparam int unsigned ADDR_W         = 20;
  localparam int unsigned RAND_W         = 31;

  localparam logic [4:0]  SYM_SPACE   = 5'd26;
  localparam logic [4:0]  SYM_DEAD    = 5'd27;
  localparam logic [14:0] CTX_THE     = {5'd19, 5'd7, 5'd4};
  localparam logic [6:0]  CHAR_SPACE  = 7'd32;
  localparam logic [6:0]  CHAR_QMARK  = 7'd63;
  localparam logic [6:0]  CHAR_A      = 7'd97;

  typedef enum logic [1:0] {
    OP_LEARN   = 2'd0,
    OP_GEN     = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L_RD,
    ST_L_WR,
    ST_G_SUM,
    ST_G_DIV_GO,
    ST_G_DIV_WAIT,
    ST_G_WALK,
    ST_OUT
  } state_t;

  // letters of either case map to 0..25, everything else to space
  function automatic logic [4:0] fold_symbol(input logic [7:0] b);
    logic [7:0] l;
    l = b;
    if (b >= 8'd65 && b <= 8'd90) l = b + 8'd32;
    if (l >= 8'd97 && l <= 8'd122) return 5'(l - 8'd97);
    return SYM_SPACE;
  endfunction

  function automatic logic ctx_ok(input logic [14:0] ctx);
    return (ctx[14:10] < 5'd27) && (ctx[9:5] < 5'd27) && (ctx[4:0] < 5'd27);
  endfunction

  // first follower address of a context: ((s3*27+s2)*27+s1)*27
  function automatic logic [ADDR_W-1:0] ctx_base(input logic [14:0] ctx);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ctx[14:10]) * ADDR_W'(27) + ADDR_W'(ctx[9:5]);
    a = a * ADDR_W'(27) + ADDR_W'(ctx[4:0]);
    return a * ADDR_W'(27);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ngm_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none
module ngm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/ngm_mod.sv -----
// bit-serial restoring modulo unit, one dividend bit per cycle
// depends on ngm_pkg
`default_nettype none
module ngm_mod #(
  parameter int unsigned SUM_W = 21
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [ngm_pkg::RAND_W-1:0] dividend,
  input  wire logic [SUM_W-1:0]         divisor,
  output logic                          done,
  output logic      [SUM_W-1:0]         remainder
);
  import ngm_pkg::*;

  logic              running;
  logic [4:0]        cnt;
  logic [RAND_W-1:0] q;
  logic [SUM_W:0]    trial;

  assign trial = {remainder, q[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        cnt       <= 5'(RAND_W - 1);
        q         <= dividend;
        remainder <= '0;
      end else if (running) begin
        q <= {q[RAND_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) remainder <= SUM_W'(trial - {1'b0, divisor});
        else remainder <= SUM_W'(trial);
        if (cnt == 5'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("modulo done held");
endmodule
`default_nettype wire

// ----- rtl/ngram_markov_char_generator_unit.sv -----
// top level of the order-3 markov character generator: sequencer, count ram, modulo unit
// depends on ngm_pkg, ngm_ram, ngm_mod
//
// channel   | direction | ports                                 | marking
// ----------+-----------+---------------------------------------+-------------------
// request   | in        | operation, char_in, random_value      | start & !busy
// result    | out       | next_char, no_continuation            | done, one cycle
//
// learn: accept, ram read, ram write; dropped space, short history,
//   restart, unused: accept only
// generate: accept, sum, modulo, walk, out, the steps set by
//   the single ram read port and the bit-serial modulo unit; dead context: accept, out
// reset: a clearing pass writes zero to all 531441 counts, busy meanwhile
// the receiver cannot stall: done is high for exactly one cycle per generate
`default_nettype none
module ngram_markov_char_generator_unit #(
  parameter int unsigned COUNT_BITS = ngm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 operation,
  input  wire logic [7:0]                 char_in,
  input  wire logic [ngm_pkg::RAND_W-1:0] random_value,
  output logic                            done,
  output logic      [6:0]                 next_char,
  output logic                            no_continuation
);
  import ngm_pkg::*;

  localparam int unsigned SUM_W = COUNT_BITS + 5;

  state_t state, state_next;

  // count ram ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  // sequencer and datapath registers
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] l_addr;
  logic [4:0]        idx;       // next follower to read
  logic [4:0]        didx;      // follower whose data is on ram_rdata
  logic              dvalid;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rr;
  logic [RAND_W-1:0] rnd;
  logic [14:0]       hist;
  logic [1:0]        filled;
  logic              pws;
  logic [14:0]       ctx;

  logic             mod_start;
  logic             mod_done;
  logic [SUM_W-1:0] mrem;

  logic       accept;
  logic [4:0] lsym;
  logic       hit;

  assign accept = start && !busy;
  assign lsym   = fold_symbol(char_in);
  // walk stops at the first follower whose count exceeds what is left of the draw
  assign hit    = dvalid && (rr < SUM_W'(ram_rdata));

  ngm_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ngm_mod #(.SUM_W(SUM_W)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rnd),
    .divisor   (sum),
    .done      (mod_done),
    .remainder (mrem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_LEARN: begin
              // a repeated space is dropped, a short history only shifts
              if (!(lsym == SYM_SPACE && pws) && filled == 2'd3) state_next = ST_L_RD;
            end
            OP_GEN:  state_next = ctx_ok(ctx) ? ST_G_SUM : ST_OUT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_L_RD:  state_next = ST_L_WR;
      ST_L_WR:  state_next = ST_IDLE;
      ST_G_SUM: begin
        if (idx == 5'(NSYM) && !dvalid) state_next = (sum == '0) ? ST_OUT : ST_G_DIV_GO;
      end
      ST_G_DIV_GO:   state_next = ST_G_DIV_WAIT;
      ST_G_DIV_WAIT: if (mod_done) state_next = ST_G_WALK;
      ST_G_WALK:     if (hit) state_next = ST_OUT;
      ST_OUT:        state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_OUT);
    mod_start  = (state == ST_G_DIV_GO);
    ram_we     = 1'b0;
    ram_waddr  = l_addr;
    ram_wdata  = '0;
    ram_raddr  = base + ADDR_W'(idx);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_L_RD: ram_raddr = l_addr;
      ST_L_WR: begin
        ram_we    = 1'b1;
        // saturating increment
        ram_wdata = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata
                                                      : ram_rdata + COUNT_BITS'(1);
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr        <= '0;
      hist            <= '0;
      filled          <= '0;
      pws             <= 1'b0;
      ctx             <= CTX_THE;
      dvalid          <= 1'b0;
      idx             <= '0;
      no_continuation <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        ST_IDLE: begin
          if (accept) begin
            case (op_t'(operation))
              OP_LEARN: begin
                if (!(lsym == SYM_SPACE && pws)) begin
                  pws    <= (lsym == SYM_SPACE);
                  l_addr <= ctx_base(hist) + ADDR_W'(lsym);
                  if (filled != 2'd3) filled <= filled + 2'd1;
                  hist <= {hist[9:0], lsym};
                end
              end
              OP_GEN: begin
                base   <= ctx_base(ctx);
                rnd    <= random_value;
                sum    <= '0;
                idx    <= '0;
                dvalid <= 1'b0;
                if (!ctx_ok(ctx)) begin
                  // dead context: no followers, keep answering '?' until restart
                  next_char       <= CHAR_QMARK;
                  no_continuation <= 1'b1;
                  ctx             <= {ctx[9:0], SYM_DEAD};
                end
              end
              OP_RESTART: ctx <= CTX_THE;
              default: ;
            endcase
          end
        end
        ST_G_SUM: begin
          if (idx != 5'(NSYM)) idx <= idx + 5'd1;
          dvalid <= (idx != 5'(NSYM));
          didx   <= idx;
          if (dvalid) sum <= sum + SUM_W'(ram_rdata);
          if (idx == 5'(NSYM) && !dvalid && sum == '0) begin
            next_char       <= CHAR_QMARK;
            no_continuation <= 1'b1;
            ctx             <= {ctx[9:0], SYM_DEAD};
          end
        end
        ST_G_DIV_WAIT: begin
          idx    <= '0;
          dvalid <= 1'b0;
          if (mod_done) rr <= mrem;
        end
        ST_G_WALK: begin
          if (idx != 5'(NSYM)) idx <= idx + 5'd1;
          dvalid <= (idx != 5'(NSYM)) && !hit;
          didx   <= idx;
          if (hit) begin
            next_char       <= (didx == SYM_SPACE) ? CHAR_SPACE : CHAR_A + 7'(didx);
            no_continuation <= 1'b0;
            ctx             <= {ctx[9:0], didx};
          end else if (dvalid) begin
            rr <= rr - SUM_W'(ram_rdata);
          end
        end
        default: ;
      endcase
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result while idle");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_qmark: assert property (@(posedge clk) disable iff (rst)
    (done && no_continuation) |-> (next_char == CHAR_QMARK))
    else $error("no continuation without question mark");
endmodule
`default_nettype wire
